@@ rtl/mtg_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mtg_pkg
// Shared types, constants and tempering function for the 32-bit twister
// generator.
// ---------------------------------------------------------------------------
package mtg_pkg;

  // state buffer geometry
  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned SA_W        = 10;
  localparam int unsigned TW_SHIFT    = 397;
  localparam int unsigned KEY_DEPTH_DEF = 64;

  // recurrence constants
  localparam logic [31:0] TW_MATRIX = 32'h9908_b0df;
  localparam logic [31:0] TW_UPPER  = 32'h8000_0000;
  localparam logic [31:0] TW_LOWER  = 32'h7fff_ffff;
  localparam logic [31:0] MUL_SEED  = 32'd1812433253;
  localparam logic [31:0] MUL_KEY1  = 32'd1664525;
  localparam logic [31:0] MUL_KEY2  = 32'd1566083941;
  localparam logic [31:0] SEED_KEY  = 32'd19650218;
  localparam logic [31:0] SEED_BOOT = 32'd5489;

  // last index and fold point of the far tap
  localparam logic [SA_W-1:0] IDX_LAST  = SA_W'(STATE_WORDS - 1);
  localparam logic [SA_W-1:0] IDX_FULL  = SA_W'(STATE_WORDS);
  localparam logic [SA_W-1:0] FAR_FOLD  = SA_W'(STATE_WORDS - TW_SHIFT);
  localparam logic [SA_W-1:0] FAR_ADD   = SA_W'(TW_SHIFT);

  // request codes
  localparam logic [1:0] CMD_SEED = 2'd0;
  localparam logic [1:0] CMD_KEY  = 2'd1;
  localparam logic [1:0] CMD_DRAW = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BOOT,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_AI1_RD,
    ST_AI1_WR,
    ST_AI2_RD,
    ST_AI2_WR,
    ST_WRAP,
    ST_FIX0,
    ST_TW_RD0,
    ST_TW_NX,
    ST_TW_FAR,
    ST_TW_WR,
    ST_DR_RD,
    ST_DR_OUT
  } state_t;

  // output tempering
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & 32'h9d2c_5680);
    y = y ^ ((y << 15) & 32'hefc6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

@@ rtl/mtg_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mtg_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mtg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mt19937_generator_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mt19937_generator_unit
// 32-bit twister generator: seed, key-array initialization and tempered
// draws, sequenced over one shared multiplier and one state RAM port.
// ---------------------------------------------------------------------------
//  channel  | ports                                    | handshake
//  request  | in_cmd, in_value, in_key_last            | start & !busy
//  result   | out_word                                 | out_valid strobe
//
//  draw: a state RAM read, then the tempered word; the state is twisted first
//    when all words are used (neighbor and far tap read per word through one read port)
//  seed: each word passes ST_SEED_MUL then ST_SEED_WR (shared multiplier)
//  key last: seed, then mixing passes over max(624,len) and 623 words, plus wraps
//  after reset the block seeds itself with 5489 and holds busy meanwhile
//  results are shown for one cycle; the receiver cannot stall
module mt19937_generator_unit #(
  parameter int unsigned KEY_DEPTH = mtg_pkg::KEY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_value,
  input  logic        in_key_last,
  output logic        out_valid,
  output logic [31:0] out_word
);

  localparam int unsigned KA_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned KC_W = $clog2(KEY_DEPTH + 1);
  localparam logic [KC_W-1:0] KEY_FULL = KC_W'(KEY_DEPTH);
  localparam int unsigned SA_W = mtg_pkg::SA_W;

  mtg_pkg::state_t state_r, state_nxt;

  logic [SA_W-1:0] idx_r, idx_nxt;
  logic [SA_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [SA_W-1:0] cnt_r, cnt_nxt;
  logic [KC_W-1:0] key_count_r, key_count_nxt;
  logic [KC_W-1:0] key_len_r, key_len_nxt;
  logic [KA_W-1:0] j_r, j_nxt;
  logic            ai_r, ai_nxt;
  logic            phase_r, phase_nxt;
  logic [31:0]     p_r, p_nxt;
  logic [31:0]     mul_r, mul_nxt;
  logic [31:0]     cur_r, cur_nxt;
  logic [31:0]     nx_r, nx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_word_r, out_word_nxt;

  // state RAM ports
  logic            st_we;
  logic [SA_W-1:0] st_waddr, st_raddr;
  logic [31:0]     st_wdata, st_rdata;

  // key RAM ports
  logic            key_we;
  logic [KA_W-1:0] key_waddr, key_raddr;
  logic [31:0]     key_rdata;

  mtg_ram #(.WIDTH(32), .DEPTH(mtg_pkg::STATE_WORDS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  mtg_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (in_value),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  logic            accept;
  logic [31:0]     mix;
  logic [31:0]     mul_k;
  logic [31:0]     prod;
  logic [31:0]     ai1_word, ai2_word, tw_y, tw_word;
  logic [SA_W-1:0] nx_idx, far_idx;
  logic [KC_W-1:0] j_inc, kc_inc;

  assign accept  = start && (state_r == mtg_pkg::ST_IDLE);
  assign busy    = (state_r != mtg_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // shared multiplier operand and constant select
  assign mix = p_r ^ (p_r >> 30);
  always_comb begin
    unique case (state_r)
      mtg_pkg::ST_AI1_RD: mul_k = mtg_pkg::MUL_KEY1;
      mtg_pkg::ST_AI2_RD: mul_k = mtg_pkg::MUL_KEY2;
      default:            mul_k = mtg_pkg::MUL_SEED;
    endcase
  end
  // only the low word of the product is kept
  assign prod = mix * mul_k;

  // word updates of the recurrences
  assign ai1_word = (st_rdata ^ mul_r) + key_rdata + 32'(j_r);
  assign ai2_word = (st_rdata ^ mul_r) - 32'(idx_r);
  assign tw_y     = (cur_r & mtg_pkg::TW_UPPER) | (nx_r & mtg_pkg::TW_LOWER);
  assign tw_word  = st_rdata ^ (tw_y >> 1) ^ (tw_y[0] ? mtg_pkg::TW_MATRIX : 32'd0);

  // neighbor and far tap addresses
  assign nx_idx  = (idx_r == mtg_pkg::IDX_LAST) ? '0 : idx_r + SA_W'(1);
  assign far_idx = (idx_r < mtg_pkg::FAR_FOLD) ? idx_r + mtg_pkg::FAR_ADD
                                               : idx_r - mtg_pkg::FAR_FOLD;
  assign j_inc   = KC_W'(j_r) + KC_W'(1);
  assign kc_inc  = key_count_r + KC_W'(1);

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtg_pkg::ST_BOOT;
      rd_idx_r    <= mtg_pkg::IDX_FULL;
      key_count_r <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
      ai_r        <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      key_count_r <= key_count_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      ai_r        <= ai_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    key_len_r  <= key_len_nxt;
    j_r        <= j_nxt;
    p_r        <= p_nxt;
    mul_r      <= mul_nxt;
    cur_r      <= cur_nxt;
    nx_r       <= nx_nxt;
    out_word_r <= out_word_nxt;
  end

  // next state and RAM controls
  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    key_count_nxt = key_count_r;
    key_len_nxt   = key_len_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    j_nxt         = j_r;
    ai_nxt        = ai_r;
    phase_nxt     = phase_r;
    p_nxt         = p_r;
    mul_nxt       = prod;
    cur_nxt       = cur_r;
    nx_nxt        = nx_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    st_we         = 1'b0;
    st_waddr      = idx_r;
    st_wdata      = p_r;
    st_raddr      = idx_r;
    key_we        = 1'b0;
    key_waddr     = key_count_r[KA_W-1:0];
    key_raddr     = j_r;

    unique case (state_r)
      mtg_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            mtg_pkg::CMD_SEED: begin
              key_count_nxt = '0;
              st_we    = 1'b1;
              st_waddr = '0;
              st_wdata = in_value;
              p_nxt    = in_value;
              idx_nxt  = SA_W'(1);
              ai_nxt   = 1'b0;
              state_nxt = mtg_pkg::ST_SEED_MUL;
            end
            mtg_pkg::CMD_KEY: begin
              // store the key word while room is left
              if (key_count_r < KEY_FULL) begin
                key_we        = 1'b1;
                key_count_nxt = kc_inc;
              end
              if (in_key_last) begin
                key_len_nxt = (key_count_r < KEY_FULL) ? kc_inc : key_count_r;
                st_we    = 1'b1;
                st_waddr = '0;
                st_wdata = mtg_pkg::SEED_KEY;
                p_nxt    = mtg_pkg::SEED_KEY;
                idx_nxt  = SA_W'(1);
                ai_nxt   = 1'b1;
                state_nxt = mtg_pkg::ST_SEED_MUL;
              end
            end
            mtg_pkg::CMD_DRAW: begin
              if (rd_idx_r >= mtg_pkg::IDX_FULL) begin
                idx_nxt   = '0;
                state_nxt = mtg_pkg::ST_TW_RD0;
              end else begin
                state_nxt = mtg_pkg::ST_DR_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      mtg_pkg::ST_BOOT: begin
        st_we    = 1'b1;
        st_waddr = '0;
        st_wdata = mtg_pkg::SEED_BOOT;
        p_nxt    = mtg_pkg::SEED_BOOT;
        idx_nxt  = SA_W'(1);
        ai_nxt   = 1'b0;
        state_nxt = mtg_pkg::ST_SEED_MUL;
      end

      mtg_pkg::ST_SEED_MUL: begin
        state_nxt = mtg_pkg::ST_SEED_WR;
      end

      // linear seeding recurrence
      mtg_pkg::ST_SEED_WR: begin
        st_we    = 1'b1;
        st_wdata = mul_r + 32'(idx_r);
        p_nxt    = mul_r + 32'(idx_r);
        if (idx_r == mtg_pkg::IDX_LAST) begin
          rd_idx_nxt = mtg_pkg::IDX_FULL;
          if (ai_r) begin
            p_nxt     = mtg_pkg::SEED_KEY;
            idx_nxt   = SA_W'(1);
            j_nxt     = '0;
            phase_nxt = 1'b0;
            cnt_nxt   = (SA_W'(key_len_r) > mtg_pkg::IDX_FULL) ? SA_W'(key_len_r)
                                                               : mtg_pkg::IDX_FULL;
            state_nxt = mtg_pkg::ST_AI1_RD;
          end else begin
            state_nxt = mtg_pkg::ST_IDLE;
          end
        end else begin
          idx_nxt   = idx_r + SA_W'(1);
          state_nxt = mtg_pkg::ST_SEED_MUL;
        end
      end

      mtg_pkg::ST_AI1_RD: begin
        state_nxt = mtg_pkg::ST_AI1_WR;
      end

      // key mixing pass
      mtg_pkg::ST_AI1_WR: begin
        st_we    = 1'b1;
        st_wdata = ai1_word;
        p_nxt    = ai1_word;
        j_nxt    = (j_inc >= key_len_r) ? '0 : j_inc[KA_W-1:0];
        idx_nxt  = (idx_r == mtg_pkg::IDX_LAST) ? SA_W'(1) : idx_r + SA_W'(1);
        if (cnt_r == SA_W'(1)) begin
          cnt_nxt   = mtg_pkg::IDX_LAST;
          phase_nxt = 1'b1;
          state_nxt = (idx_r == mtg_pkg::IDX_LAST) ? mtg_pkg::ST_WRAP
                                                   : mtg_pkg::ST_AI2_RD;
        end else begin
          cnt_nxt   = cnt_r - SA_W'(1);
          state_nxt = (idx_r == mtg_pkg::IDX_LAST) ? mtg_pkg::ST_WRAP
                                                   : mtg_pkg::ST_AI1_RD;
        end
      end

      mtg_pkg::ST_AI2_RD: begin
        state_nxt = mtg_pkg::ST_AI2_WR;
      end

      // second mixing pass
      mtg_pkg::ST_AI2_WR: begin
        st_we    = 1'b1;
        st_wdata = ai2_word;
        p_nxt    = ai2_word;
        idx_nxt  = (idx_r == mtg_pkg::IDX_LAST) ? SA_W'(1) : idx_r + SA_W'(1);
        cnt_nxt  = cnt_r - SA_W'(1);
        if (cnt_r == SA_W'(1)) begin
          state_nxt = mtg_pkg::ST_FIX0;
        end else if (idx_r == mtg_pkg::IDX_LAST) begin
          state_nxt = mtg_pkg::ST_WRAP;
        end else begin
          state_nxt = mtg_pkg::ST_AI2_RD;
        end
      end

      // word 0 takes the last word on wrap
      mtg_pkg::ST_WRAP: begin
        st_we    = 1'b1;
        st_waddr = '0;
        st_wdata = p_r;
        state_nxt = phase_r ? mtg_pkg::ST_AI2_RD : mtg_pkg::ST_AI1_RD;
      end

      mtg_pkg::ST_FIX0: begin
        st_we         = 1'b1;
        st_waddr      = '0;
        st_wdata      = mtg_pkg::TW_UPPER;
        rd_idx_nxt    = mtg_pkg::IDX_FULL;
        key_count_nxt = '0;
        state_nxt     = mtg_pkg::ST_IDLE;
      end

      // twist: read word 0, then per word read neighbor and far tap
      mtg_pkg::ST_TW_RD0: begin
        st_raddr  = '0;
        state_nxt = mtg_pkg::ST_TW_NX;
      end

      mtg_pkg::ST_TW_NX: begin
        st_raddr = nx_idx;
        if (idx_r == '0) begin
          cur_nxt = st_rdata;
        end
        state_nxt = mtg_pkg::ST_TW_FAR;
      end

      mtg_pkg::ST_TW_FAR: begin
        st_raddr  = far_idx;
        nx_nxt    = st_rdata;
        state_nxt = mtg_pkg::ST_TW_WR;
      end

      mtg_pkg::ST_TW_WR: begin
        st_we    = 1'b1;
        st_wdata = tw_word;
        cur_nxt  = nx_r;
        if (idx_r == mtg_pkg::IDX_LAST) begin
          rd_idx_nxt = '0;
          state_nxt  = mtg_pkg::ST_DR_RD;
        end else begin
          idx_nxt   = idx_r + SA_W'(1);
          state_nxt = mtg_pkg::ST_TW_NX;
        end
      end

      mtg_pkg::ST_DR_RD: begin
        st_raddr  = rd_idx_r;
        state_nxt = mtg_pkg::ST_DR_OUT;
      end

      mtg_pkg::ST_DR_OUT: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = mtg_pkg::temper(st_rdata);
        rd_idx_nxt    = rd_idx_r + SA_W'(1);
        state_nxt     = mtg_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = mtg_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // an accepted seed, draw or last key request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && ((in_cmd == mtg_pkg::CMD_SEED) || (in_cmd == mtg_pkg::CMD_DRAW) ||
                        ((in_cmd == mtg_pkg::CMD_KEY) && in_key_last))) |=> busy)
    else $error("accepted request did not raise busy");

  // a result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // no result while a request is in work
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // key count stays within the key store
  a_key_bound: assert property (@(posedge clk) disable iff (!rst_n)
    key_count_r <= KEY_FULL)
    else $error("key count beyond key store depth");
`endif

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the 32-bit twister generator unit against its own predictor. Seed,
// key-load and draw requests go in through the start/busy handshake, with
// random sender gaps. Each drawn word is compared with the predicted
// tempered state word.
// ---------------------------------------------------------------------------
module testbench;

  localparam int unsigned KEYS = mtg_pkg::KEY_DEPTH_DEF;
  localparam int unsigned NWORDS = mtg_pkg::STATE_WORDS;
  localparam logic [1:0] CMD_NONE = 2'd3;

  // scoreboard with its own copy of the generator state
  class mt_scoreboard;
    logic [31:0] words[NWORDS];
    int unsigned next_word;
    logic [31:0] key_words[KEYS];
    int unsigned key_fill;
    logic [31:0] pending_words[$];
    int unsigned mismatches;

    function new();
      key_fill = 0;
      mismatches = 0;
      seed_state(mtg_pkg::SEED_BOOT);
    endfunction

    function void seed_state(logic [31:0] s);
      logic [31:0] p;
      words[0] = s;
      for (int j = 1; j < NWORDS; j++) begin
        p = words[j-1];
        words[j] = 32'(mtg_pkg::MUL_SEED * (p ^ (p >> 30))) + 32'(j);
      end
      next_word = NWORDS;
    endfunction

    function void key_init(int unsigned len);
      int unsigned i, j, k;
      logic [31:0] p;
      seed_state(mtg_pkg::SEED_KEY);
      i = 1;
      j = 0;
      for (k = (NWORDS > len) ? NWORDS : len; k != 0; k--) begin
        p = words[i-1];
        words[i] = (words[i] ^ 32'((p ^ (p >> 30)) * mtg_pkg::MUL_KEY1))
                   + key_words[j] + 32'(j);
        i++;
        if (i >= NWORDS) begin
          words[0] = words[NWORDS-1];
          i = 1;
        end
        j++;
        if (j >= len) j = 0;
      end
      for (k = NWORDS - 1; k != 0; k--) begin
        p = words[i-1];
        words[i] = (words[i] ^ 32'((p ^ (p >> 30)) * mtg_pkg::MUL_KEY2)) - 32'(i);
        i++;
        if (i >= NWORDS) begin
          words[0] = words[NWORDS-1];
          i = 1;
        end
      end
      words[0] = mtg_pkg::TW_UPPER;
      next_word = NWORDS;
    endfunction

    function void regenerate();
      logic [31:0] y;
      for (int i = 0; i < NWORDS; i++) begin
        y = (words[i] & mtg_pkg::TW_UPPER) | (words[(i+1) % NWORDS] & mtg_pkg::TW_LOWER);
        words[i] = words[(i + mtg_pkg::TW_SHIFT) % NWORDS] ^ (y >> 1)
                   ^ (y[0] ? mtg_pkg::TW_MATRIX : 32'd0);
      end
      next_word = 0;
    endfunction

    function logic [31:0] shape_word(logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & 32'h9d2c_5680);
      y = y ^ ((y << 15) & 32'hefc6_0000);
      return y ^ (y >> 18);
    endfunction

    // accepted request: advance the state, queue a word for draws
    function void note_request(logic [1:0] cmd, logic [31:0] value, logic last);
      case (cmd)
        mtg_pkg::CMD_SEED: begin
          key_fill = 0;
          seed_state(value);
        end
        mtg_pkg::CMD_KEY: begin
          if (key_fill < KEYS) begin
            key_words[key_fill] = value;
            key_fill++;
          end
          if (last) begin
            key_init(key_fill);
            key_fill = 0;
          end
        end
        mtg_pkg::CMD_DRAW: begin
          if (next_word >= NWORDS) regenerate();
          pending_words.push_back(shape_word(words[next_word]));
          next_word++;
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic [31:0] got);
      logic [31:0] exp_word;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %08h", got);
        return;
      end
      exp_word = pending_words.pop_front();
      if (got !== exp_word) begin
        mismatches++;
        if (mismatches <= 10) $display("word mismatch: expected %08h got %08h", exp_word, got);
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, in_key_last, out_valid;
  logic [1:0] in_cmd;
  logic [31:0] in_value, out_word;
  mt_scoreboard sb;
  int unsigned gap_pct;
  int unsigned sent;

  mt19937_generator_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_value(in_value), .in_key_last(in_key_last),
    .out_valid(out_valid), .out_word(out_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_word(out_word);
  end

  // one request, returns at the edge that accepts it with start still high
  task automatic send(logic [1:0] cmd, logic [31:0] value, logic last);
    start <= 1'b1;
    in_cmd <= cmd;
    in_value <= value;
    in_key_last <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(cmd, value, last);
    sent++;
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      in_cmd <= 2'($urandom);
      in_value <= $urandom;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic key_sequence(int unsigned len);
    for (int unsigned n = 0; n < len; n++)
      send(mtg_pkg::CMD_KEY, $urandom, n == len - 1);
  endtask

  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned r;
    sb = new();
    sent = 0;
    gap_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = mtg_pkg::CMD_DRAW;
    in_value = '0;
    in_key_last = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: boot seed, field extremes, key corner cases
    send(mtg_pkg::CMD_DRAW, 32'hffff_ffff, 1'b1);
    send(mtg_pkg::CMD_DRAW, 32'h0, 1'b0);
    send(CMD_NONE, 32'hffff_ffff, 1'b1);
    send(mtg_pkg::CMD_SEED, 32'h0, 1'b1);
    send(mtg_pkg::CMD_DRAW, 32'h0, 1'b0);
    send(mtg_pkg::CMD_SEED, 32'hffff_ffff, 1'b0);
    send(mtg_pkg::CMD_DRAW, 32'h0, 1'b1);
    send(mtg_pkg::CMD_KEY, 32'h0, 1'b1);
    send(mtg_pkg::CMD_DRAW, 32'h0, 1'b0);
    send(mtg_pkg::CMD_KEY, 32'hffff_ffff, 1'b1);
    send(mtg_pkg::CMD_DRAW, 32'h0, 1'b0);
    // seed in the middle of a key discards it
    send(mtg_pkg::CMD_KEY, 32'h1234_5678, 1'b0);
    send(mtg_pkg::CMD_KEY, 32'h8765_4321, 1'b0);
    send(mtg_pkg::CMD_SEED, 32'h0000_1571, 1'b0);
    send(mtg_pkg::CMD_DRAW, 32'h0, 1'b0);
    send(mtg_pkg::CMD_KEY, 32'h0000_0123, 1'b0);
    send(mtg_pkg::CMD_KEY, 32'h0000_0234, 1'b0);
    send(mtg_pkg::CMD_KEY, 32'h0000_0345, 1'b0);
    send(mtg_pkg::CMD_KEY, 32'h0000_0456, 1'b1);
    send(mtg_pkg::CMD_DRAW, 32'h0, 1'b0);
    drain();
    // key store overflow, last word dropped but still starts init
    key_sequence(KEYS + 6);
    send(mtg_pkg::CMD_DRAW, 32'h0, 1'b0);
    drain();

    // random part in idling phases
    while (sent < 1700) begin
      case ((sent / 150) % 4)
        0: gap_pct = 0;
        1: gap_pct = 75;
        2: gap_pct = 0;
        default: gap_pct = 30;
      endcase
      r = $urandom_range(0, 999);
      if (r < 25) send(mtg_pkg::CMD_SEED, $urandom, 1'($urandom));
      else if (r < 45) key_sequence($urandom_range(1, 8));
      else if (r < 47) key_sequence(KEYS + $urandom_range(0, 3));
      else if (r < 60) send(CMD_NONE, $urandom, 1'($urandom));
      else if (r < 70) send(mtg_pkg::CMD_KEY, $urandom, 1'b0);
      else if (r < 73) drain();
      else send(mtg_pkg::CMD_DRAW, $urandom, 1'($urandom));
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
